// ----- rtl/core/depv_pkg.sv -----
// depv_pkg: shared types, codes and saturation helpers for the dual encoder
// position and velocity estimator; no dependencies, compiled first
package depv_pkg;

  localparam int unsigned DataW      = 32;
  localparam int unsigned MagW       = 52;
  localparam int unsigned CntW       = $clog2(MagW + 1);
  localparam int unsigned ProdW      = 64;
  localparam int unsigned AngleShift = 14;
  localparam int unsigned ShiftW     = ProdW - AngleShift;
  localparam logic signed [DataW-1:0] UsPerSec = 32'sd1000000;
  localparam logic [DataW-1:0] SatMax = 32'h7fff_ffff;
  localparam logic [DataW-1:0] SatMin = 32'h8000_0000;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_UNAVAIL = 2'd1,
    STATUS_ZERO_DT = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_ENABLE    = 2'd0,
    REG_SCALE_ONE = 2'd1,
    REG_SCALE_TWO = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MUL_JOINT_ONE = 2'd0,
    MUL_JOINT_TWO = 2'd1,
    MUL_DIFF_ONE  = 2'd2,
    MUL_DIFF_TWO  = 2'd3
  } mul_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_ONE,
    ST_MUL_TWO,
    ST_ANGLE_TWO,
    ST_DIFF_ONE,
    ST_DIFF_TWO,
    ST_DIV_LOAD,
    ST_DIVIDE,
    ST_RESULT
  } ctrl_state_e;

  typedef struct packed {
    logic        [31:0] sample_time_us;
    logic        [31:0] sample_sequence;
    logic signed [31:0] encoder_one_count;
    logic signed [31:0] encoder_two_count;
  } sample_t;

  typedef struct packed {
    logic        [1:0]  status_code;
    logic        [31:0] out_sequence;
    logic        [31:0] out_time_us;
    logic signed [31:0] angle_one;
    logic signed [31:0] rate_one;
    logic signed [31:0] angle_two;
    logic signed [31:0] rate_two;
  } result_t;

  typedef struct packed {
    logic     capture;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     angle_one_ld;
    logic     angle_two_ld;
    logic     num_one_ld;
    logic     div_start;
    logic     finish;
  } dp_cmd_t;

  typedef struct packed {
    logic enable;
    logic primed;
    logic dt_zero;
    logic div_busy;
  } dp_stat_t;

  // floor of a Q2.30 by count product to Q16.16, clamped to 32 bits
  function automatic logic [DataW-1:0] sat_angle(input logic [ProdW-1:0] prod);
    logic [ShiftW-1:0] s;
    s = prod[ProdW-1:AngleShift];
    if ((&s[ShiftW-1:DataW-1]) || !(|s[ShiftW-1:DataW-1])) begin
      return s[DataW-1:0];
    end else if (s[ShiftW-1]) begin
      return SatMin;
    end else begin
      return SatMax;
    end
  endfunction

  // signed quotient from magnitude and sign, clamped to 32 bits
  function automatic logic [DataW-1:0] sat_rate(input logic [MagW-1:0] q, input logic neg);
    if (neg) begin
      if ((|q[MagW-1:DataW]) || (q[DataW-1] && (|q[DataW-2:0]))) begin
        return SatMin;
      end else begin
        return ~q[DataW-1:0] + 32'd1;
      end
    end else if (|q[MagW-1:DataW-1]) begin
      return SatMax;
    end else begin
      return q[DataW-1:0];
    end
  endfunction

endpackage

// ----- rtl/core/depv_div.sv -----
// depv_div: two-lane restoring divider, one quotient bit per lane each cycle
// over a shared 32-bit divisor; depends on depv_pkg
module depv_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [depv_pkg::MagW-1:0] num_a_i,
  input  logic [depv_pkg::MagW-1:0] num_b_i,
  input  logic [31:0]               den_i,
  output logic                      busy_o,
  output logic [depv_pkg::MagW-1:0] quo_a_o,
  output logic [depv_pkg::MagW-1:0] quo_b_o
);
  import depv_pkg::*;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [31:0]     den_q;
  logic [31:0]     rem_q [2];
  logic [31:0]     rem_d [2];
  logic [MagW-1:0] quo_q [2];
  logic [MagW-1:0] quo_d [2];
  logic [32:0]     trial [2];
  logic            ge    [2];

  assign busy_o  = (cnt_q != '0);
  assign quo_a_o = quo_q[0];
  assign quo_b_o = quo_q[1];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      trial[i] = {rem_q[i], quo_q[i][MagW-1]};
      ge[i]    = (trial[i] >= {1'b0, den_q});
      rem_d[i] = ge[i] ? 32'(trial[i] - {1'b0, den_q}) : trial[i][31:0];
      quo_d[i] = {quo_q[i][MagW-2:0], ge[i]};
    end
    cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CntW'(MagW);
    end else if (busy_o) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q    <= den_i;
      rem_q[0] <= '0;
      rem_q[1] <= '0;
      quo_q[0] <= num_a_i;
      quo_q[1] <= num_b_i;
    end else if (busy_o) begin
      rem_q[0] <= rem_d[0];
      rem_q[1] <= rem_d[1];
      quo_q[0] <= quo_d[0];
      quo_q[1] <= quo_d[1];
    end
  end

endmodule

// ----- rtl/core/depv_dp.sv -----
// depv_dp: configuration and state registers, shared multiplier, divider and
// result register; depends on depv_pkg and depv_div
module depv_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [31:0]       cfg_wdata_i,
  input  depv_pkg::sample_t sample_i,
  input  depv_pkg::dp_cmd_t cmd_i,
  output depv_pkg::dp_stat_t stat_o,
  output depv_pkg::result_t result_o
);
  import depv_pkg::*;

  logic              enable_q;
  logic [31:0]       scale_one_q, scale_two_q;
  logic              primed_q;
  logic [31:0]       last_time_q, last_angle_one_q, last_angle_two_q;
  sample_t           sample_q;
  logic [ProdW-1:0]  prod_q, num_one_q;
  logic [31:0]       angle_one_q, angle_two_q;
  logic              neg_one_q, neg_two_q;
  result_t           result_q, result_d;

  logic signed [32:0]      mul_a;
  logic signed [31:0]      mul_b;
  logic signed [64:0]      mul_p;
  logic signed [32:0]      diff_one, diff_two;
  logic [31:0]             dt;
  logic [ProdW-1:0]        abs_one, abs_two;
  logic                    div_busy;
  logic [MagW-1:0]         quo_one, quo_two;

  assign diff_one = $signed({angle_one_q[31], angle_one_q})
                  - $signed({last_angle_one_q[31], last_angle_one_q});
  assign diff_two = $signed({angle_two_q[31], angle_two_q})
                  - $signed({last_angle_two_q[31], last_angle_two_q});
  assign dt       = sample_q.sample_time_us - last_time_q;

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_JOINT_ONE: begin
        mul_a = {sample_q.encoder_one_count[31], sample_q.encoder_one_count};
        mul_b = scale_one_q;
      end
      MUL_JOINT_TWO: begin
        mul_a = {sample_q.encoder_two_count[31], sample_q.encoder_two_count};
        mul_b = scale_two_q;
      end
      MUL_DIFF_ONE: begin
        mul_a = diff_one;
        mul_b = UsPerSec;
      end
      MUL_DIFF_TWO: begin
        mul_a = diff_two;
        mul_b = UsPerSec;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  assign abs_one = num_one_q[ProdW-1] ? (~num_one_q + 64'd1) : num_one_q;
  assign abs_two = prod_q[ProdW-1] ? (~prod_q + 64'd1) : prod_q;

  depv_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_a_i (abs_one[MagW-1:0]),
    .num_b_i (abs_two[MagW-1:0]),
    .den_i   (dt),
    .busy_o  (div_busy),
    .quo_a_o (quo_one),
    .quo_b_o (quo_two)
  );

  assign stat_o.enable   = enable_q;
  assign stat_o.primed   = primed_q;
  assign stat_o.dt_zero  = (dt == '0);
  assign stat_o.div_busy = div_busy;

  always_comb begin
    result_d = '0;
    if (!enable_q) begin
      result_d.status_code = STATUS_UNAVAIL;
    end else begin
      result_d.status_code  = (primed_q && stat_o.dt_zero) ? STATUS_ZERO_DT : STATUS_OK;
      result_d.out_sequence = primed_q ? sample_q.sample_sequence : '0;
      result_d.out_time_us  = sample_q.sample_time_us;
      result_d.angle_one    = angle_one_q;
      result_d.angle_two    = angle_two_q;
      if (primed_q && !stat_o.dt_zero) begin
        result_d.rate_one = sat_rate(quo_one, neg_one_q);
        result_d.rate_two = sat_rate(quo_two, neg_two_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q         <= 1'b0;
      scale_one_q      <= '0;
      scale_two_q      <= '0;
      primed_q         <= 1'b0;
      last_time_q      <= '0;
      last_angle_one_q <= '0;
      last_angle_two_q <= '0;
    end else begin
      if (cmd_i.finish && enable_q) begin
        primed_q         <= 1'b1;
        last_time_q      <= sample_q.sample_time_us;
        last_angle_one_q <= angle_one_q;
        last_angle_two_q <= angle_two_q;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_ENABLE: begin
            enable_q         <= cfg_wdata_i[0];
            primed_q         <= 1'b0;
            last_time_q      <= '0;
            last_angle_one_q <= '0;
            last_angle_two_q <= '0;
          end
          REG_SCALE_ONE: scale_one_q <= cfg_wdata_i;
          REG_SCALE_TWO: scale_two_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sample_q <= sample_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_p[ProdW-1:0];
    end
    if (cmd_i.angle_one_ld) begin
      angle_one_q <= sat_angle(prod_q);
    end
    if (cmd_i.angle_two_ld) begin
      angle_two_q <= sat_angle(prod_q);
    end
    if (cmd_i.num_one_ld) begin
      num_one_q <= prod_q;
    end
    if (cmd_i.div_start) begin
      neg_one_q <= num_one_q[ProdW-1];
      neg_two_q <= prod_q[ProdW-1];
    end
    if (cmd_i.finish) begin
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

endmodule

// ----- rtl/core/depv_ctrl.sv -----
// depv_ctrl: sequencer for one sample and the result valid flag
// depends on depv_pkg
module depv_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  depv_pkg::dp_stat_t stat_i,
  output depv_pkg::dp_cmd_t  cmd_o
);
  import depv_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q;
  logic        slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign in_ready_o  = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = stat_i.enable ? ST_MUL_ONE : ST_RESULT;
        end
      end
      ST_MUL_ONE:   state_d = ST_MUL_TWO;
      ST_MUL_TWO:   state_d = ST_ANGLE_TWO;
      ST_ANGLE_TWO: begin
        state_d = (stat_i.primed && !stat_i.dt_zero) ? ST_DIFF_ONE : ST_RESULT;
      end
      ST_DIFF_ONE:  state_d = ST_DIFF_TWO;
      ST_DIFF_TWO:  state_d = ST_DIV_LOAD;
      ST_DIV_LOAD:  state_d = ST_DIVIDE;
      ST_DIVIDE: begin
        if (!stat_i.div_busy) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: cmd_o.capture = in_valid_i;
      ST_MUL_ONE: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_JOINT_ONE;
      end
      ST_MUL_TWO: begin
        cmd_o.angle_one_ld = 1'b1;
        cmd_o.mul_en       = 1'b1;
        cmd_o.mul_sel      = MUL_JOINT_TWO;
      end
      ST_ANGLE_TWO: cmd_o.angle_two_ld = 1'b1;
      ST_DIFF_ONE: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_DIFF_ONE;
      end
      ST_DIFF_TWO: begin
        cmd_o.num_one_ld = 1'b1;
        cmd_o.mul_en     = 1'b1;
        cmd_o.mul_sel    = MUL_DIFF_TWO;
      end
      ST_DIV_LOAD: cmd_o.div_start = 1'b1;
      ST_RESULT:   cmd_o.finish = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/dual_encoder_position_velocity.sv -----
// dual_encoder_position_velocity: top level joining sequencer and datapath
// depends on depv_pkg, depv_ctrl, depv_dp and depv_div
//
// usage: a sample request (timestamp, sequence, two encoder counts) enters on
// sample_valid_i/sample_ready_o and yields exactly one result request on
// result_valid_o/result_ready_i. registers are written through cfg_we_i with
// cfg_index_i (0 enable, 1 and 2 the joint scales) while the block is idle,
// which the user must keep, as the block does not enforce it; writing enable
// clears the stored time and angles. while disabled an accepted sample goes
// straight to the result step; the initializing sample or a zero interval
// first takes the two angle passes. a full sample adds the divider: both
// joints divide in parallel, one quotient bit per cycle over 52 bits,
// after two shared multiplier passes for the angles and two for the
// scaled differences. a new sample is taken the cycle after the previous
// result is loaded; a finished result waits in the output register while
// the next sample is accepted and worked on.
// reset clears config, history, state and the output valid. when the receiver
// stalls, the next result waits in its last step until the output frees.
module dual_encoder_position_velocity (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [31:0]       cfg_wdata_i,
  input  logic              sample_valid_i,
  output logic              sample_ready_o,
  input  depv_pkg::sample_t sample_req_i,
  output logic              result_valid_o,
  input  logic              result_ready_i,
  output depv_pkg::result_t result_req_o
);
  import depv_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  depv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_valid_i),
    .in_ready_o  (sample_ready_o),
    .out_valid_o (result_valid_o),
    .out_ready_i (result_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  depv_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sample_i    (sample_req_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .result_o    (result_req_o)
  );

endmodule
